// File: sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths and status type for the trial division prime test unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VAL_W  = 32;
	localparam int DIV_W  = VAL_W / 2 + 1;
	localparam int SQ_W   = 2 * DIV_W;
	localparam int CNT_W  = $clog2(VAL_W);
	localparam int OUT_W  = 8;

	localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
	localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);
	localparam logic [VAL_W-1:0] SMALL_PRIME = VAL_W'(2);

	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

// File: sv/tdpt_serial_rem.sv
// ----------------------------------------------------------------------------
// tdpt_serial_rem
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tdpt_serial_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tdpt_pkg::VAL_W-1:0]    dividend,
	input  logic [tdpt_pkg::DIV_W-1:0]    divisor,
	output logic                          busy,
	output tdpt_pkg::rem_stat_t           stat
);

	localparam logic [tdpt_pkg::CNT_W-1:0] LAST = tdpt_pkg::CNT_W'(tdpt_pkg::VAL_W - 1);

	logic [tdpt_pkg::VAL_W-1:0] shift_q;
	logic [tdpt_pkg::DIV_W-1:0] rem_q;
	logic [tdpt_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic [tdpt_pkg::DIV_W:0]   trial;
	logic [tdpt_pkg::DIV_W:0]   div_ext;
	logic [tdpt_pkg::DIV_W-1:0] rem_nxt;

	assign trial   = {rem_q, shift_q[tdpt_pkg::VAL_W-1]};
	assign div_ext = {1'b0, divisor};
	assign rem_nxt = (trial >= div_ext) ? tdpt_pkg::DIV_W'(trial - div_ext)
	                                    : tdpt_pkg::DIV_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + tdpt_pkg::CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[tdpt_pkg::VAL_W-2:0], shift_q[tdpt_pkg::VAL_W-1]};
			rem_q   <= rem_nxt;
		end
	end

	assign busy      = busy_q;
	assign stat.done = busy_q && (cnt_q == LAST);
	assign stat.zero = (rem_nxt == '0);

endmodule

// File: sv/tdpt_divisor_gen.sv
// ----------------------------------------------------------------------------
// tdpt_divisor_gen
// Odd trial divisor and its running square, stepped by addition only.
// ----------------------------------------------------------------------------
module tdpt_divisor_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          init,
	input  logic                          step,
	input  logic [tdpt_pkg::VAL_W-1:0]    value,
	output logic [tdpt_pkg::DIV_W-1:0]    divisor,
	output logic                          in_range
);

	logic [tdpt_pkg::DIV_W-1:0] div_q;
	logic [tdpt_pkg::SQ_W-1:0]  sq_q;

	// (d+2)^2 = d^2 + 4d + 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= tdpt_pkg::FIRST_DIV;
			sq_q  <= tdpt_pkg::FIRST_SQ;
		end else if (init) begin
			div_q <= tdpt_pkg::FIRST_DIV;
			sq_q  <= tdpt_pkg::FIRST_SQ;
		end else if (step) begin
			div_q <= div_q + tdpt_pkg::DIV_W'(2);
			sq_q  <= sq_q + tdpt_pkg::SQ_W'({div_q, 2'b00}) + tdpt_pkg::SQ_W'(4);
		end
	end

	assign divisor  = div_q;
	assign in_range = (sq_q <= tdpt_pkg::SQ_W'(value));

endmodule

// File: sv/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test of a 32-bit unsigned word by odd trial division.
// ----------------------------------------------------------------------------
// Input stream s_*: one 32-bit word per test, taken when s_tvalid and
// s_tready are high together. s_tready is high only while no test runs.
// Output stream m_*: one word per test, is_prime in bit 0 of m_tdata.
// For values 0, 1, 2 and even values no trial division runs; m_tvalid rises
// and s_tready returns together when the result enters the output register.
// Odd values step through divisors 3, 5, 7, ... while the divisor squared is
// no more than the value; each divisor costs one range check plus a pass of
// the bit-serial remainder unit, one dividend bit a cycle (the divisor steps
// on the last bit). Worst case, a prime near 2^32, is about 32768 divisors.
// The square is tracked by addition, so no multiplier is used.
// The output register frees the input side: a new word is taken while the
// previous result waits for m_tready. A finished result that finds the
// output still occupied waits in the unit until the receiver takes the old
// one. Reset (arst_n low) drops any test in flight and clears m_tvalid.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tdpt_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tdpt_pkg::OUT_W-1:0]    m_tdata    // [0] is_prime, [7:1] zero
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0]                 state_q;
	logic [tdpt_pkg::VAL_W-1:0] held_q;
	logic                       prime_q;
	logic                       m_tvalid_q;
	logic                       m_prime_q;
	logic                       accept;
	logic                       in_range;
	logic                       rem_start;
	logic                       rem_busy;
	logic                       div_step;
	logic [tdpt_pkg::DIV_W-1:0] divisor;
	tdpt_pkg::rem_stat_t        rem_stat;
	logic                       out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign rem_start = (state_q == ST_CHECK) && in_range;
	assign div_step  = (state_q == ST_DIV) && rem_stat.done && !rem_stat.zero;

	tdpt_divisor_gen u_divisor_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (accept),
		.step     (div_step),
		.value    (held_q),
		.divisor  (divisor),
		.in_range (in_range)
	);

	tdpt_serial_rem u_serial_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (held_q),
		.divisor  (divisor),
		.busy     (rem_busy),
		.stat     (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			prime_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						held_q <= s_tdata;
						if (s_tdata == tdpt_pkg::SMALL_PRIME) begin
							prime_q <= 1'b1;
							state_q <= ST_RESULT;
						end else if (!s_tdata[0] || s_tdata == tdpt_pkg::VAL_W'(1)) begin
							prime_q <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (!in_range) begin
						prime_q <= 1'b1;
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							prime_q <= 1'b0;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			m_prime_q <= prime_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(tdpt_pkg::OUT_W-1){1'b0}}, m_prime_q};

	a_start_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> (state_q == ST_CHECK && !rem_busy))
		else $error("remainder started outside range check");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> rem_busy)
		else $error("waiting on idle remainder unit");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && prime_q) |->
		(held_q == tdpt_pkg::SMALL_PRIME || (held_q[0] && held_q != tdpt_pkg::VAL_W'(1))))
		else $error("even or unit value reported prime");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not moved to output register");

endmodule
